// ===== rtl/core/pixel_alpha_flatten_to_color_top_assert.svh =====
// Assertion macros shared by the checker of the alpha flatten block.
// Needs nothing but a clock and an active-low reset at the point of use.
`ifndef PIXEL_ALPHA_FLATTEN_TO_COLOR_TOP_ASSERT_SVH
`define PIXEL_ALPHA_FLATTEN_TO_COLOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define PAFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PAFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pafc_pkg.sv =====
// Shared types, register map and helpers for the alpha flatten block.
// No dependencies.
`timescale 1ns / 1ps

package pafc_pkg;

  localparam logic [7:0] CHAN_MAX = 8'd255;

  localparam logic [2:0] REG_INVERTED = 3'd0;
  localparam logic [2:0] REG_TARGET_A = 3'd1;
  localparam logic [2:0] REG_TARGET_R = 3'd2;
  localparam logic [2:0] REG_TARGET_G = 3'd3;
  localparam logic [2:0] REG_TARGET_B = 3'd4;

  typedef struct packed {
    logic       inverted;
    logic [7:0] target_a;
    logic [7:0] target_r;
    logic [7:0] target_g;
    logic [7:0] target_b;
  } cfg_t;

  // Truncating division by 255, exact for inputs up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

endpackage

// ===== rtl/core/pafc_pipe.sv =====
// Three-stage blend pipeline: products, sums, then divide by 255 and select.
// Depends on pafc_pkg.
`timescale 1ns / 1ps

module pafc_pipe import pafc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] pixel_red_i,
  input  logic [7:0] pixel_green_i,
  input  logic [7:0] pixel_blue_i,
  input  logic [7:0] pixel_alpha_i,
  input  logic       frame_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic [7:0] out_alpha_o,
  output logic       out_frame_end_o
);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  logic [15:0] pr_q, pg_q, pb_q, tr_q, tg_q, tb_q, ap1_q;
  logic        last1_q;
  logic [7:0]  inv_a;

  logic [15:0] sr_q, sg_q, sb_q, ap2_q;
  logic        last2_q;

  logic [7:0]  red_q, green_q, blue_q, alpha_q;
  logic        last3_q;
  logic [7:0]  alpha_div;

  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  assign inv_a = CHAN_MAX - pixel_alpha_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      pr_q    <= 16'(pixel_red_i) * 16'(pixel_alpha_i);
      pg_q    <= 16'(pixel_green_i) * 16'(pixel_alpha_i);
      pb_q    <= 16'(pixel_blue_i) * 16'(pixel_alpha_i);
      tr_q    <= 16'(cfg_i.target_r) * 16'(inv_a);
      tg_q    <= 16'(cfg_i.target_g) * 16'(inv_a);
      tb_q    <= 16'(cfg_i.target_b) * 16'(inv_a);
      ap1_q   <= cfg_i.inverted ? 16'(cfg_i.target_a) * 16'(pixel_alpha_i)
                                : 16'(CHAN_MAX - cfg_i.target_a) * 16'(pixel_alpha_i);
      last1_q <= frame_end_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      sr_q    <= pr_q + tr_q;
      sg_q    <= pg_q + tg_q;
      sb_q    <= pb_q + tb_q;
      ap2_q   <= ap1_q;
      last2_q <= last1_q;
    end
  end

  assign alpha_div = div255(ap2_q);

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      if (cfg_i.inverted) begin
        red_q   <= cfg_i.target_r;
        green_q <= cfg_i.target_g;
        blue_q  <= cfg_i.target_b;
        alpha_q <= cfg_i.target_a - alpha_div;
      end else begin
        red_q   <= div255(sr_q);
        green_q <= div255(sg_q);
        blue_q  <= div255(sb_q);
        alpha_q <= cfg_i.target_a + alpha_div;
      end
      last3_q <= last2_q;
    end
  end

  assign out_valid_o     = v3_q;
  assign out_red_o       = red_q;
  assign out_green_o     = green_q;
  assign out_blue_o      = blue_q;
  assign out_alpha_o     = alpha_q;
  assign out_frame_end_o = last3_q;

endmodule

// ===== rtl/core/pixel_alpha_flatten_to_color_top.sv =====
// Flattens RGBA pixels onto a programmable solid color, with an inverted mode.
// Accepted beats pass the product, sum and divide/select stage registers.
// Throughput is one beat per cycle, less when out_stall_i holds the pipeline.
// Reset clears all valid bits and sets every configuration register to zero.
// Depends on pafc_pkg and pafc_pipe.
`timescale 1ns / 1ps

module pixel_alpha_flatten_to_color_top import pafc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pixel_red_i,
  input  logic [7:0]  pixel_green_i,
  input  logic [7:0]  pixel_blue_i,
  input  logic [7:0]  pixel_alpha_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic [7:0]  out_alpha_o,
  output logic        out_frame_end_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_INVERTED: cfg_q.inverted <= pwdata[0];
        REG_TARGET_A: cfg_q.target_a <= pwdata[7:0];
        REG_TARGET_R: cfg_q.target_r <= pwdata[7:0];
        REG_TARGET_G: cfg_q.target_g <= pwdata[7:0];
        REG_TARGET_B: cfg_q.target_b <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_INVERTED: prdata = {31'd0, cfg_q.inverted};
      REG_TARGET_A: prdata = {24'd0, cfg_q.target_a};
      REG_TARGET_R: prdata = {24'd0, cfg_q.target_r};
      REG_TARGET_G: prdata = {24'd0, cfg_q.target_g};
      REG_TARGET_B: prdata = {24'd0, cfg_q.target_b};
      default:      prdata = 32'd0;
    endcase
  end

  pafc_pipe u_pipe (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pixel_red_i     (pixel_red_i),
    .pixel_green_i   (pixel_green_i),
    .pixel_blue_i    (pixel_blue_i),
    .pixel_alpha_i   (pixel_alpha_i),
    .frame_end_i     (frame_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_red_o       (out_red_o),
    .out_green_o     (out_green_o),
    .out_blue_o      (out_blue_o),
    .out_alpha_o     (out_alpha_o),
    .out_frame_end_o (out_frame_end_o)
  );

endmodule

// ===== rtl/core/pafc_checker.sv =====
// Port-level checker for the alpha flatten block, bound to its top level.
// Depends on the assertion macro header.
`timescale 1ns / 1ps
`include "pixel_alpha_flatten_to_color_top_assert.svh"

module pafc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  out_red_o,
  input logic [7:0]  out_green_o,
  input logic [7:0]  out_blue_o,
  input logic [7:0]  out_alpha_o,
  input logic        out_frame_end_o
);

  `PAFC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_red_o) && $stable(out_green_o) && $stable(out_blue_o) && $stable(out_alpha_o) && $stable(out_frame_end_o), "Stalled output beat changed.")
  `PAFC_ASSERT_IMP(a_stall_full, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "Input stalled while the output side could drain.")
  `PAFC_ASSERT_NXT(a_latency, clk_i, rst_ni, in_valid_i && !in_stall_o && !out_stall_i ##1 !out_stall_i ##1 !out_stall_i, out_valid_o, "Accepted beat did not reach the output in three cycles.")

endmodule

bind pixel_alpha_flatten_to_color_top pafc_checker u_pafc_checker (.*);
